// ----- hw/rtl/fupd_pkg.sv -----
// shared types, constants and helper functions of the uri-list percent decoder
package fupd_pkg;

    // default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // length of the "file://" prefix, also the count value that means matched
    localparam logic [2:0] PREFIX_LEN = 3'd7;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // one classified input item as it sits in the queue
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eod;
        logic       term;
        logic       pct;
        logic       hex_ok;
        logic [3:0] hex_val;
    } item_t;

    // escape decoder phases
    typedef enum logic [2:0] {
        ESC_SEARCH = 3'b001,
        ESC_PCT    = 3'b010,
        ESC_DIGIT  = 3'b100
    } esc_state_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // expected byte at each position of "file://"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            3'd0: c = 8'h66;  // f
            3'd1: c = 8'h69;  // i
            3'd2: c = 8'h6C;  // l
            3'd3: c = 8'h65;  // e
            3'd4: c = 8'h3A;  // :
            3'd5: c = 8'h2F;  // /
            3'd6: c = 8'h2F;  // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // hex digit value of an ascii byte
    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'h0;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok  = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- hw/rtl/fupd_front.sv -----
// front part: accepts input items and classifies each byte
module fupd_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output fupd_pkg::item_t   q_item
);

    fupd_pkg::hex_t hex;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign hex      = fupd_pkg::hex_decode(s_tdata);

    always_comb begin
        q_item.byte_val = s_tdata;
        q_item.eod      = s_tlast;
        q_item.term     = (s_tdata == fupd_pkg::CHAR_NUL) || (s_tdata == fupd_pkg::CHAR_LF)
                          || (s_tdata == fupd_pkg::CHAR_CR);
        q_item.pct      = (s_tdata == fupd_pkg::CHAR_PERCENT);
        q_item.hex_ok   = hex.ok;
        q_item.hex_val  = hex.val;
    end

endmodule

// ----- hw/rtl/fupd_fifo.sv -----
// short queue of classified items between front and back
module fupd_fifo #(
    parameter int DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fupd_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output fupd_pkg::item_t   pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fupd_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/fupd_back.sv -----
// back part: line filter, escape decoder and output register
module fupd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  fupd_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic [2:0]             count_reg, count_next;
    logic                   rej_reg, rej_next;
    fupd_pkg::esc_state_t   esc_reg, esc_next;
    logic [3:0]             nib_reg, nib_next;

    logic                   has;
    logic [7:0]             val;
    logic                   pend;
    logic                   search;
    logic [7:0]             escaped;

    logic                   m_valid_reg;
    logic [7:0]             m_data_reg;
    logic                   m_user_reg;
    logic                   m_last_reg;

    assign q_pop   = q_not_empty && (!m_valid_reg || m_tready);
    assign escaped = {nib_reg, q_item.hex_val};

    always_comb begin
        count_next = count_reg;
        rej_next   = rej_reg;
        esc_next   = esc_reg;
        nib_next   = nib_reg;
        has        = 1'b0;
        val        = 8'h00;
        pend       = 1'b0;
        search     = 1'b0;
        if (q_item.term) begin
            pend       = (count_reg == fupd_pkg::PREFIX_LEN) && !rej_reg;
            count_next = '0;
            rej_next   = 1'b0;
            esc_next   = fupd_pkg::ESC_SEARCH;
            nib_next   = 4'h0;
        end else begin
            if (rej_reg) begin
                // rest of a rejected line is ignored
                count_next = count_reg;
            end else if (count_reg != fupd_pkg::PREFIX_LEN) begin
                if (q_item.byte_val == fupd_pkg::prefix_char(count_reg)) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    rej_next = 1'b1;
                end
            end else begin
                unique case (esc_reg)
                    fupd_pkg::ESC_PCT: begin
                        if (q_item.hex_ok) begin
                            nib_next = q_item.hex_val;
                            esc_next = fupd_pkg::ESC_DIGIT;
                        end else begin
                            esc_next = fupd_pkg::ESC_SEARCH;
                        end
                    end
                    fupd_pkg::ESC_DIGIT: begin
                        esc_next = fupd_pkg::ESC_SEARCH;
                        if (q_item.hex_ok) begin
                            // decoded zero is dropped
                            if (escaped != 8'h00) begin
                                has = 1'b1;
                                val = escaped;
                            end
                        end else begin
                            search = 1'b1;
                        end
                    end
                    default: begin
                        esc_next = fupd_pkg::ESC_SEARCH;
                        search   = 1'b1;
                    end
                endcase
                if (search) begin
                    if (q_item.pct) begin
                        esc_next = fupd_pkg::ESC_PCT;
                    end else begin
                        has = 1'b1;
                        val = q_item.byte_val;
                    end
                end
            end
            if (q_item.eod) begin
                pend       = (count_next == fupd_pkg::PREFIX_LEN) && !rej_next;
                count_next = '0;
                rej_next   = 1'b0;
                esc_next   = fupd_pkg::ESC_SEARCH;
                nib_next   = 4'h0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rej_reg     <= 1'b0;
            esc_reg     <= fupd_pkg::ESC_SEARCH;
            nib_reg     <= 4'h0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                count_reg <= count_next;
                rej_reg   <= rej_next;
                esc_reg   <= esc_next;
                nib_reg   <= nib_next;
            end
            if (q_pop && (has || pend)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && (has || pend)) begin
            m_data_reg <= val;
            m_user_reg <= has;
            m_last_reg <= pend;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hw/rtl/file_uri_list_percent_decoder_top.sv -----
// top level of the uri-list percent decoder
// path: an accepted input item is written into the queue, then its result is registered in the output register
// throughput: one item per cycle, sustained while m_tready stays high
// the queue of FIFO_DEPTH items absorbs short output stalls
// reset: synchronous, active low; clears line state, queue and output valid
// no clearing pass, the block takes items in the first cycle after reset
module file_uri_list_percent_decoder_top #(
    parameter int FIFO_DEPTH = fupd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // end_of_drop, a line end follows this byte
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_value, zero when no byte
    output logic       m_tuser,    // [0] has_byte
    output logic       m_tlast     // path_end, a kept path ends with this item
);

    // front to queue
    logic              q_push;
    logic              q_full;
    fupd_pkg::item_t   q_push_item;

    // queue to back
    logic              q_pop;
    logic              q_not_empty;
    fupd_pkg::item_t   q_pop_item;

    // front classifies each byte: line terminator, percent sign, hex digit
    fupd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    // short queue decouples input acceptance from output stalls
    fupd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_pop_item)
    );

    // back runs the prefix filter and escape decoder, one item per cycle unless a
    // held result stalls it, and holds the result in an output register
    fupd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (q_pop_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- hw/rtl/fupd_checker.sv -----
// port-level checks of the uri-list percent decoder, bound to the top level
module fupd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // every result carries a byte, a path end, or both
    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("result with neither byte nor path end");

    // data is zero when no byte is carried
    a_no_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'h00))
        else $error("data not zero on a path-end-only result");

    // a decoded byte is never zero
    a_byte_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata != 8'h00))
        else $error("zero byte sent out");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled result changed");

    // the input only stalls behind a held result
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |-> m_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind file_uri_list_percent_decoder_top fupd_checker u_fupd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/file_uri_list_percent_decoder_checker.sv -----
`timescale 1ns / 100ps
// result checker of the uri-list percent decoder: predicts decoded path items and compares them
module file_uri_list_percent_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // end_of_drop
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [7:0] out_value
    input  logic       m_tuser,    // [0] has_byte
    input  logic       m_tlast,    // path_end
    output int         fail_count,
    output int         expected_left
);

    typedef struct packed {
        logic       has_byte;
        logic [7:0] value;
        logic       path_end;
    } path_item_t;

    localparam logic [55:0] FILE_PREFIX = "file://";

    path_item_t decoded_q[$];

    logic [2:0]           match_cnt;
    logic                 rejected;
    fupd_pkg::esc_state_t esc_phase;
    logic [3:0]           high_nibble;

    function automatic void clear_line();
        match_cnt   = 3'd0;
        rejected    = 1'b0;
        esc_phase   = fupd_pkg::ESC_SEARCH;
        high_nibble = 4'h0;
    endfunction

    // {ok, value} of an ascii hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] h;
        h = 5'h00;
        if (b >= "0" && b <= "9") begin
            h = {1'b1, 4'(b - "0")};
        end else if (b >= "a" && b <= "f") begin
            h = {1'b1, 4'(b - "a" + 8'd10)};
        end else if (b >= "A" && b <= "F") begin
            h = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return h;
    endfunction

    // advances the line state by one input byte, returns 1 when a result follows
    function automatic logic decode_uri_byte(input logic [7:0] b, input logic eod,
                                             output path_item_t r);
        logic [4:0] h;
        logic       kept;
        logic       searching;
        r = '0;
        if (b == fupd_pkg::CHAR_NUL || b == fupd_pkg::CHAR_LF || b == fupd_pkg::CHAR_CR) begin
            r.path_end = (match_cnt == fupd_pkg::PREFIX_LEN) && !rejected;
            clear_line();
        end else begin
            if (rejected) begin
                // rest of a rejected line is ignored
            end else if (match_cnt != fupd_pkg::PREFIX_LEN) begin
                if (b == FILE_PREFIX[55 - 8 * match_cnt -: 8])
                    match_cnt = match_cnt + 3'd1;
                else
                    rejected = 1'b1;
            end else begin
                h = hex_digit(b);
                searching = 1'b0;
                case (esc_phase)
                    fupd_pkg::ESC_PCT: begin
                        if (h[4]) begin
                            high_nibble = h[3:0];
                            esc_phase   = fupd_pkg::ESC_DIGIT;
                        end else begin
                            esc_phase = fupd_pkg::ESC_SEARCH;
                        end
                    end
                    fupd_pkg::ESC_DIGIT: begin
                        esc_phase = fupd_pkg::ESC_SEARCH;
                        if (h[4]) begin
                            if ({high_nibble, h[3:0]} != 8'h00) begin
                                r.has_byte = 1'b1;
                                r.value    = {high_nibble, h[3:0]};
                            end
                        end else begin
                            searching = 1'b1;
                        end
                    end
                    default: searching = 1'b1;
                endcase
                if (searching) begin
                    if (b == fupd_pkg::CHAR_PERCENT) begin
                        esc_phase = fupd_pkg::ESC_PCT;
                    end else begin
                        esc_phase  = fupd_pkg::ESC_SEARCH;
                        r.has_byte = 1'b1;
                        r.value    = b;
                    end
                end
            end
            if (eod) begin
                kept = (match_cnt == fupd_pkg::PREFIX_LEN) && !rejected;
                r.path_end = kept;
                clear_line();
            end
        end
        return r.has_byte || r.path_end;
    endfunction

    always @(posedge aclk) begin
        path_item_t predicted;
        path_item_t want;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            decoded_q.delete();
            clear_line();
            fail_count    <= 0;
            expected_left <= 0;
        end else begin
            // results are compared before this edge's input is predicted
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected item: has_byte %0d out_value 0x%02h path_end %0d",
                           m_tuser, m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser !== want.has_byte) begin
                        $error("has_byte: expected %0d, got %0d", want.has_byte, m_tuser);
                        errs++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("out_value: expected 0x%02h, got 0x%02h", want.value, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.path_end) begin
                        $error("path_end: expected %0d, got %0d", want.path_end, m_tlast);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (decode_uri_byte(s_tdata, s_tlast, predicted))
                    decoded_q.push_back(predicted);
            end
            fail_count    <= fail_count + errs;
            expected_left <= decoded_q.size();
        end
    end

endmodule

// ----- tb/file_uri_list_percent_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// testbench top of the uri-list percent decoder: stimulus, stalls, watchdog and verdict
module file_uri_list_percent_decoder_top_tb;

    // cycles without any accepted item before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the long receiver hold-off
    localparam int HOLD_LEN = 150;
    // settling time after the last expected item
    localparam int TAIL_CYCLES = 20;
    // input items per random phase
    localparam int PHASE_ITEMS = 75;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // end_of_drop
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_value
    logic       m_tuser;            // [0] has_byte
    logic       m_tlast;            // path_end

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_items    = 0;
    int idle_run       = 0;
    // long hold-off requested by the stimulus, served by the receiver process
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_cycles    = 0;
    int fail_count;
    int expected_left;

    file_uri_list_percent_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    file_uri_list_percent_decoder_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_cycles <= HOLD_LEN;
            m_tready    <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("file_uri_list_percent_decoder_top_tb failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // offers one item, with random sender gaps ahead of it, and waits for its acceptance
    task automatic send_item(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        phase_items++;
    endtask

    // eod rides on the last byte when asked
    task automatic send_text(input string txt, input logic eod_at_end);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], eod_at_end && (i == txt.len() - 1));
    endtask

    function automatic logic [7:0] hex_char();
        logic [7:0] c;
        case ($urandom_range(2))
            0:       c = 8'("0" + $urandom_range(9));
            1:       c = 8'("a" + $urandom_range(5));
            default: c = 8'("A" + $urandom_range(5));
        endcase
        return c;
    endfunction

    // any byte that is neither a hex digit nor a line terminator
    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c inside {fupd_pkg::CHAR_LF, fupd_pkg::CHAR_CR, [8'h30:8'h39], [8'h41:8'h46],
                         [8'h61:8'h66]})
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // one chunk of a path: plain bytes, escapes good and bad, or noise
    task automatic send_path_piece();
        int kind;
        kind = $urandom_range(10);
        case (kind)
            0, 1, 2: send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            3:       send_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
            4, 5: begin
                send_item(fupd_pkg::CHAR_PERCENT, 1'b0);
                send_item(hex_char(), 1'b0);
                send_item(hex_char(), 1'b0);
            end
            6:       send_text("%00", 1'b0);
            7: begin
                // bad first digit
                send_item(fupd_pkg::CHAR_PERCENT, 1'b0);
                send_item(non_hex_char(), 1'b0);
            end
            8: begin
                // bad second digit, which may itself open an escape
                send_item(fupd_pkg::CHAR_PERCENT, 1'b0);
                send_item(hex_char(), 1'b0);
                send_item(non_hex_char(), 1'b0);
            end
            9: begin
                // escape likely cut by what follows
                send_item(fupd_pkg::CHAR_PERCENT, 1'b0);
                if ($urandom_range(1))
                    send_item(hex_char(), 1'b0);
            end
            default: send_item(8'($urandom_range(255)), 1'b0);
        endcase
    endtask

    // one line: mostly a well-formed file path, otherwise a broken prefix or noise
    task automatic send_random_line();
        string      pfx;
        int         kind;
        int         pos;
        int         n;
        logic [7:0] b;
        pfx  = "file://";
        kind = $urandom_range(99);
        if (kind < 75) begin
            send_text(pfx, 1'b0);
        end else if (kind < 88) begin
            // prefix with one bit flipped, or cut short
            pos = $urandom_range(6);
            for (int i = 0; i < 7; i++) begin
                if (kind < 81 && i == pos)
                    break;
                b = pfx[i];
                if (i == pos)
                    b = b ^ (8'h01 << $urandom_range(7));
                send_item(b, 1'b0);
            end
        end else begin
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                send_item(8'($urandom_range(255)), 1'b0);
        end
        n = $urandom_range(8);
        for (int i = 0; i < n; i++)
            send_path_piece();
        case ($urandom_range(9))
            0, 1, 2: send_item(fupd_pkg::CHAR_LF, $urandom_range(3) == 0);
            3:       send_item(fupd_pkg::CHAR_CR, 1'b0);
            4:       send_item(fupd_pkg::CHAR_NUL, $urandom_range(1) == 1);
            5, 6, 7: begin
                // buffer end on a final byte, sometimes one that cuts an escape
                if ($urandom_range(1))
                    send_item(fupd_pkg::CHAR_PERCENT, 1'b1);
                else
                    send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
            end
            8: begin
                send_item(fupd_pkg::CHAR_CR, 1'b0);
                send_item(fupd_pkg::CHAR_LF, 1'b0);
            end
            default: ;  // no terminator, the next line runs on
        endcase
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling
        send_item(fupd_pkg::CHAR_LF, 1'b0);       // empty line
        send_text("fi\r", 1'b0);                  // short line
        send_text("file://", 1'b0);               // bare prefix ended by nul
        send_item(fupd_pkg::CHAR_NUL, 1'b1);
        // good escape, bad first digit, bad second digit then a good one,
        // zero escape, mixed-case ff, high byte, escape cut by buffer end
        send_text("file://%4a%gZ%4%41%00%fF", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("%3", 1'b1);
        send_text("File://x", 1'b1);              // case-sensitive prefix

        // long receiver hold-off while the sender keeps offering
        hold_requests <= hold_requests + 1;
        phase_items = 0;
        while (phase_items < 30)
            send_random_line();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_random_line();
        end

        // drain: nothing more offered, receiver always ready
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        recv_stall_pct = 0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_left == 0) begin
            $display("file_uri_list_percent_decoder_top_tb passed");
        end else begin
            $display("file_uri_list_percent_decoder_top_tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fupd_pkg.sv
hw/rtl/fupd_front.sv
hw/rtl/fupd_fifo.sv
hw/rtl/fupd_back.sv
hw/rtl/file_uri_list_percent_decoder_top.sv
hw/rtl/fupd_checker.sv
tb/file_uri_list_percent_decoder_checker.sv
tb/file_uri_list_percent_decoder_top_tb.sv
